>>> hw/rtl/dlrt_pkg.sv
// Shared types and constants for the deadline and reload timer bank.
// Used by the bank modules and the core top level; depends on nothing.
package dlrt_pkg;

   // Default bank sizes
   localparam int DLRT_DEADLINE_TIMERS = 8;
   localparam int DLRT_RELOAD_TIMERS   = 4;

   localparam int DLRT_VALUE_W  = 32;
   localparam int DLRT_INDEX_W  = 3;
   localparam int DLRT_STATUS_W = 2;
   localparam int DLRT_CMD_W    = 4;

   // Command codes carried in each request word
   typedef enum logic [DLRT_CMD_W-1:0] {
      CMD_TICK       = 4'd0,
      CMD_WR_DEADLINE = 4'd1,
      CMD_WR_STATUS  = 4'd2,
      CMD_WR_RELOAD  = 4'd3,
      CMD_WR_PENDING = 4'd4,
      CMD_RD_DEADLINE = 4'd5,
      CMD_RD_RELOAD  = 4'd6,
      CMD_RD_PENDING = 4'd7,
      CMD_CHECK      = 4'd8
   } command_type;

   // Deadline timer status codes
   typedef logic [DLRT_STATUS_W-1:0] status_type;
   localparam status_type ST_UNSET   = 2'd0;
   localparam status_type ST_ARMED   = 2'd1;
   localparam status_type ST_MISSED  = 2'd2;
   localparam status_type ST_INVALID = 2'd3;

   // One decoded request word
   typedef struct packed {
      command_type              command;
      logic [DLRT_INDEX_W-1:0]  timer_index;
      logic [DLRT_VALUE_W-1:0]  write_value;
      status_type               write_status;
   } op_type;

   // Deadline bank answer for one request word
   typedef struct packed {
      logic [DLRT_VALUE_W-1:0]  read_value;
      status_type               read_status;
      logic                     missed_found;
      logic [DLRT_INDEX_W-1:0]  missed_index;
   } dl_result_type;

   // One response word
   typedef struct packed {
      logic [DLRT_INDEX_W-1:0]  missed_index;
      logic                     missed_found;
      status_type               read_status;
      logic [DLRT_VALUE_W-1:0]  read_value;
   } rsp_type;

endpackage

>>> hw/rtl/dlrt_deadline_bank.sv
// Bank of signed deadline timers: counts, status, tick update and missed check.
// Depends on dlrt_pkg.
module dlrt_deadline_bank
   import dlrt_pkg::*;
#(
   parameter int TIMERS = DLRT_DEADLINE_TIMERS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          apply,
   input  op_type        op,
   output dl_result_type result
);

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   logic [DLRT_VALUE_W-1:0] count_ff  [TIMERS];
   logic [DLRT_VALUE_W-1:0] count_in  [TIMERS];
   status_type              status_ff [TIMERS];
   status_type              status_in [TIMERS];

   logic          in_bank;
   logic [IW-1:0] sel;

   assign in_bank = 32'(op.timer_index) < TIMERS;
   assign sel     = IW'(op.timer_index);

   // Work out the next bank contents and the answer for this word
   always_comb begin
      logic                    found;
      logic [DLRT_INDEX_W-1:0] where;
      found = 1'b0;
      where = '0;
      for (int i = 0; i < TIMERS; i++) begin
         count_in[i]  = count_ff[i];
         status_in[i] = status_ff[i];
      end
      case (op.command)
         CMD_TICK: begin
            // decrement all, arm check on the wrapped value
            for (int i = 0; i < TIMERS; i++) begin
               count_in[i] = count_ff[i] - 1'b1;
               if (status_ff[i] == ST_ARMED &&
                   (count_in[i] == '0 || count_in[i][DLRT_VALUE_W-1])) begin
                  status_in[i] = ST_MISSED;
               end
            end
         end
         CMD_WR_DEADLINE: begin
            if (in_bank) begin
               count_in[sel] = op.write_value;
            end
         end
         CMD_WR_STATUS: begin
            if (in_bank && op.write_status != ST_INVALID) begin
               status_in[sel] = op.write_status;
            end
         end
         CMD_CHECK: begin
            // highest missed index wins; clear every missed timer
            for (int i = 0; i < TIMERS; i++) begin
               if (status_ff[i] == ST_MISSED) begin
                  found        = 1'b1;
                  where        = DLRT_INDEX_W'(i);
                  status_in[i] = ST_UNSET;
               end
            end
         end
         default: begin
         end
      endcase
      result.missed_found = found;
      result.missed_index = where;
      result.read_status  = in_bank ? status_in[sel] : ST_UNSET;
      result.read_value   = (in_bank && op.command == CMD_RD_DEADLINE) ?
                            count_ff[sel] : '0;
   end

   // Commit the new bank contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            count_ff[i]  <= '0;
            status_ff[i] <= ST_UNSET;
         end
      end else if (apply) begin
         for (int i = 0; i < TIMERS; i++) begin
            count_ff[i]  <= count_in[i];
            status_ff[i] <= status_in[i];
         end
      end
   end

endmodule

>>> hw/rtl/dlrt_reload_bank.sv
// Bank of reloadable countdown timers with pending reload values.
// Depends on dlrt_pkg.
module dlrt_reload_bank
   import dlrt_pkg::*;
#(
   parameter int TIMERS = DLRT_RELOAD_TIMERS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    apply,
   input  op_type                  op,
   output logic [DLRT_VALUE_W-1:0] read_value
);

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   logic [DLRT_VALUE_W-1:0] count_ff   [TIMERS];
   logic [DLRT_VALUE_W-1:0] count_in   [TIMERS];
   logic [DLRT_VALUE_W-1:0] pending_ff [TIMERS];
   logic [DLRT_VALUE_W-1:0] pending_in [TIMERS];

   logic          in_bank;
   logic [IW-1:0] sel;

   assign in_bank = 32'(op.timer_index) < TIMERS;
   assign sel     = IW'(op.timer_index);

   // Work out the next counts and pending reloads
   always_comb begin
      for (int i = 0; i < TIMERS; i++) begin
         count_in[i]   = count_ff[i];
         pending_in[i] = pending_ff[i];
      end
      case (op.command)
         CMD_TICK: begin
            // count down, or load pending minus one once at zero
            for (int i = 0; i < TIMERS; i++) begin
               if (count_ff[i] != '0) begin
                  count_in[i] = count_ff[i] - 1'b1;
               end else if (pending_ff[i] != '0) begin
                  count_in[i]   = pending_ff[i] - 1'b1;
                  pending_in[i] = '0;
               end
            end
         end
         CMD_WR_RELOAD: begin
            if (in_bank) begin
               count_in[sel] = op.write_value;
            end
         end
         CMD_WR_PENDING: begin
            if (in_bank) begin
               pending_in[sel] = op.write_value;
            end
         end
         default: begin
         end
      endcase
   end

   // Select the read data
   always_comb begin
      read_value = '0;
      if (in_bank) begin
         case (op.command)
            CMD_RD_RELOAD:  read_value = count_ff[sel];
            CMD_RD_PENDING: read_value = pending_ff[sel];
            default:        read_value = '0;
         endcase
      end
   end

   // Commit the new bank contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            count_ff[i]   <= '0;
            pending_ff[i] <= '0;
         end
      end else if (apply) begin
         for (int i = 0; i < TIMERS; i++) begin
            count_ff[i]   <= count_in[i];
            pending_ff[i] <= pending_in[i];
         end
      end
   end

endmodule

>>> hw/rtl/deadline_and_reload_timer_bank_core.sv
// Top level of the deadline and reload timer bank: request register, the two
// timer banks and the response register. Depends on dlrt_pkg and both banks.
//
//  Channel | Dir | Handshake             | Word
//  --------+-----+-----------------------+------------------------------------
//  req     | in  | req_tvalid/req_tready | command, index, value, status
//  rsp     | out | rsp_tvalid/rsp_tready | read value, status, missed flag/idx
//
// One word per cycle sustained while rsp is not stalled. After the request
// accept the word waits in the request register while the banks update,
// and the response register loads it once that register is free or draining.
// A tick updates all timers in parallel with one decrementer per timer, and
// a check uses a priority encoder over the deadline bank. Reset clears all
// counts, pending reloads and status.
// A stalled response holds the request register, which then stalls req.
module deadline_and_reload_timer_bank_core
   import dlrt_pkg::*;
#(
   parameter int DEADLINE_TIMERS = DLRT_DEADLINE_TIMERS,
   parameter int RELOAD_TIMERS   = DLRT_RELOAD_TIMERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] command, [6:4] timer_index, [38:7] write_value,
   // [40:39] write_status, [47:41] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_value, [33:32] read_status, [34] missed_found,
   // [37:35] missed_index, [39:38] zero
   output logic [39:0] rsp_tdata
);

   logic          s1_valid_ff;
   op_type        s1_op_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          advance;
   op_type        req_op;
   dl_result_type dl_result;
   logic [DLRT_VALUE_W-1:0] rl_read_value;

   // Unpack the request word
   assign req_op.command      = command_type'(req_tdata[3:0]);
   assign req_op.timer_index  = req_tdata[6:4];
   assign req_op.write_value  = req_tdata[38:7];
   assign req_op.write_status = req_tdata[40:39];

   // Move a word into the response register when it is free or draining
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Hold the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff <= req_op;
      end
   end

   dlrt_deadline_bank #(
      .TIMERS (DEADLINE_TIMERS)
   ) u_deadline_bank (
      .clock  (clock),
      .reset  (reset),
      .apply  (advance),
      .op     (s1_op_ff),
      .result (dl_result)
   );

   dlrt_reload_bank #(
      .TIMERS (RELOAD_TIMERS)
   ) u_reload_bank (
      .clock      (clock),
      .reset      (reset),
      .apply      (advance),
      .op         (s1_op_ff),
      .read_value (rl_read_value)
   );

   // Register the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.read_value   <= dl_result.read_value | rl_read_value;
         rsp_data_ff.read_status  <= dl_result.read_status;
         rsp_data_ff.missed_found <= dl_result.missed_found;
         rsp_data_ff.missed_index <= dl_result.missed_index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response register not loaded after advance");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_op_ff))
      else $error("request word lost while stalled");

   a_no_missed_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.missed_found |-> rsp_data_ff.missed_index == '0)
      else $error("missed index without a missed timer");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.read_status != ST_INVALID)
      else $error("invalid status reported");

   a_read_only_on_reads: assert property (@(posedge clock) disable iff (reset)
      advance && !(s1_op_ff.command == CMD_RD_DEADLINE ||
                   s1_op_ff.command == CMD_RD_RELOAD ||
                   s1_op_ff.command == CMD_RD_PENDING)
      |=> rsp_data_ff.read_value == '0)
      else $error("read value nonzero on a non-read command");
`endif

endmodule

>>> dv/dlrt_rsp_checker.sv
// Response checker for the deadline and reload timer bank core.
// Watches the req and rsp channels, keeps its own copy of every timer, predicts
// each response word and compares it. Depends on dlrt_pkg.
module dlrt_rsp_checker
   import dlrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          error_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RL_IW = (DLRT_RELOAD_TIMERS > 1) ? $clog2(DLRT_RELOAD_TIMERS) : 1;

   // Shadow copy of the timer banks
   logic [DLRT_VALUE_W-1:0] dl_count   [DLRT_DEADLINE_TIMERS];
   status_type              dl_status  [DLRT_DEADLINE_TIMERS];
   logic [DLRT_VALUE_W-1:0] rl_count   [DLRT_RELOAD_TIMERS];
   logic [DLRT_VALUE_W-1:0] rl_pending [DLRT_RELOAD_TIMERS];

   // Response words predicted but not yet seen on rsp
   rsp_type predicted_rsp_q[$];

   // Apply one request word to the shadow banks and build its response
   task automatic apply_command(input logic [47:0] word, output rsp_type answer);
      logic [DLRT_CMD_W-1:0]    cmd;
      logic [DLRT_INDEX_W-1:0]  idx;
      logic [RL_IW-1:0]         ridx;
      logic [DLRT_VALUE_W-1:0]  val;
      status_type               st;
      logic                     dok;
      logic                     rok;
      cmd  = word[3:0];
      idx  = word[6:4];
      ridx = RL_IW'(idx);
      val  = word[38:7];
      st   = word[40:39];
      dok  = idx < DLRT_DEADLINE_TIMERS;
      rok  = idx < DLRT_RELOAD_TIMERS;
      answer = '0;
      case (cmd)
         CMD_TICK: begin
            // Decrement every deadline with wrap; armed at or below zero is missed
            for (int i = 0; i < DLRT_DEADLINE_TIMERS; i++) begin
               dl_count[i] = dl_count[i] - 1'b1;
               if (dl_status[i] == ST_ARMED && (dl_count[i] == '0 || dl_count[i][31]))
                  dl_status[i] = ST_MISSED;
            end
            // Count down, or load pending minus one when at zero
            for (int i = 0; i < DLRT_RELOAD_TIMERS; i++) begin
               if (rl_count[i] != '0) begin
                  rl_count[i] = rl_count[i] - 1'b1;
               end else if (rl_pending[i] != '0) begin
                  rl_count[i]   = rl_pending[i] - 1'b1;
                  rl_pending[i] = '0;
               end
            end
         end
         CMD_WR_DEADLINE: if (dok) dl_count[idx] = val;
         CMD_WR_STATUS:   if (dok && st != ST_INVALID) dl_status[idx] = st;
         CMD_WR_RELOAD:   if (rok) rl_count[ridx] = val;
         CMD_WR_PENDING:  if (rok) rl_pending[ridx] = val;
         CMD_RD_DEADLINE: if (dok) answer.read_value = dl_count[idx];
         CMD_RD_RELOAD:   if (rok) answer.read_value = rl_count[ridx];
         CMD_RD_PENDING:  if (rok) answer.read_value = rl_pending[ridx];
         CMD_CHECK: begin
            // Highest missed index wins; clear every missed timer
            for (int i = 0; i < DLRT_DEADLINE_TIMERS; i++) begin
               if (dl_status[i] == ST_MISSED) begin
                  answer.missed_found = 1'b1;
                  answer.missed_index = i[DLRT_INDEX_W-1:0];
                  dl_status[i]        = ST_UNSET;
               end
            end
         end
         default: ;
      endcase
      if (dok) answer.read_status = dl_status[idx];
   endtask

   // Compare accepted responses first, then predict the accepted request
   always @(posedge clock) begin : watch
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DLRT_DEADLINE_TIMERS; i++) begin
            dl_count[i]  = '0;
            dl_status[i] = ST_UNSET;
         end
         for (int i = 0; i < DLRT_RELOAD_TIMERS; i++) begin
            rl_count[i]   = '0;
            rl_pending[i] = '0;
         end
         predicted_rsp_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[37:0];
            if (predicted_rsp_q.size() == 0) begin
               if (error_count < 10)
                  $display("checker: unexpected rsp word %h at %0t", rsp_tdata, $realtime);
               error_count++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (seen.read_value !== want.read_value ||
                   seen.read_status !== want.read_status ||
                   seen.missed_found !== want.missed_found ||
                   seen.missed_index !== want.missed_index ||
                   rsp_tdata[39:38] !== 2'b00) begin
                  if (error_count < 10)
                     $display({"checker: rsp mismatch at %0t: read_value exp %h got %h, ",
                               "read_status exp %0d got %0d, missed_found exp %0d got %0d, ",
                               "missed_index exp %0d got %0d, pad got %b"},
                              $realtime, want.read_value, seen.read_value,
                              want.read_status, seen.read_status,
                              want.missed_found, seen.missed_found,
                              want.missed_index, seen.missed_index, rsp_tdata[39:38]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tdata, want);
            predicted_rsp_q.push_back(want);
         end
      end
      outstanding = predicted_rsp_q.size();
   end

endmodule

>>> dv/deadline_and_reload_timer_bank_core_tb.sv
// Top of the testbench for deadline_and_reload_timer_bank_core: clock, reset,
// request stimulus, response back-pressure and the verdict.
// Depends on dlrt_pkg, the core and dlrt_rsp_checker.
module deadline_and_reload_timer_bank_core_tb;
   import dlrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Command codes the core does not decode
   localparam logic [DLRT_CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
   localparam logic [DLRT_CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

   localparam int ITEMS_PER_PHASE = 350;
   localparam int LONG_HOLD       = 300;
   localparam int MAX_GAP         = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [3:0] command, [6:4] timer_index, [38:7] write_value,
   // [40:39] write_status, [47:41] zero
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [31:0] read_value, [33:32] read_status, [34] missed_found,
   // [37:35] missed_index, [39:38] zero
   logic [39:0] rsp_tdata;

   int error_count;
   int outstanding;
   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int hold_requests  = 0;

   deadline_and_reload_timer_bank_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dlrt_rsp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up long after the slowest correct run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Drive rsp_tready: random stalls, plus a long hold-off when one is requested
   initial begin
      int hold_left;
      int served;
      hold_left = 0;
      served    = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && served != hold_requests) begin
            served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one request word, called at a falling edge; returns at a falling edge
   task automatic send_req(input logic [DLRT_CMD_W-1:0] cmd,
                           input logic [DLRT_INDEX_W-1:0] idx,
                           input logic [DLRT_VALUE_W-1:0] val,
                           input status_type st);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, st, val, idx, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Often small counts so deadlines run out, with the signed extremes and random values mixed in
   function automatic logic [DLRT_VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0, 1, 2: return $urandom_range(6);
         3:       return 32'hFFFF_FFFF;
         4:       return 32'h8000_0000;
         5:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [DLRT_CMD_W-1:0] cmd;
      status_type            st;
      int                    pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset values, wrap of the most negative count, ignored writes,
      // reload handoff, check with and without misses, undecoded commands
      send_req(CMD_RD_DEADLINE, 3'd0, 32'h0, ST_UNSET);
      send_req(CMD_RD_RELOAD,   3'd3, 32'h0, ST_UNSET);
      send_req(CMD_RD_PENDING,  3'd4, 32'hFFFF_FFFF, ST_INVALID);
      send_req(CMD_WR_DEADLINE, 3'd0, 32'h1, ST_UNSET);
      send_req(CMD_WR_STATUS,   3'd0, 32'h0, ST_ARMED);
      send_req(CMD_WR_DEADLINE, 3'd7, 32'h8000_0000, ST_UNSET);
      send_req(CMD_WR_STATUS,   3'd7, 32'h0, ST_ARMED);
      send_req(CMD_WR_DEADLINE, 3'd3, 32'hFFFF_FFFF, ST_INVALID);
      send_req(CMD_WR_PENDING,  3'd1, 32'h3, ST_UNSET);
      send_req(CMD_WR_PENDING,  3'd2, 32'h1, ST_UNSET);
      send_req(CMD_WR_RELOAD,   3'd3, 32'hFFFF_FFFF, ST_UNSET);
      send_req(CMD_WR_RELOAD,   3'd5, 32'h7, ST_UNSET);
      send_req(CMD_WR_STATUS,   3'd2, 32'h0, ST_INVALID);
      send_req(CMD_TICK,        3'd0, 32'h0, ST_UNSET);
      send_req(CMD_RD_DEADLINE, 3'd7, 32'h0, ST_UNSET);
      send_req(CMD_RD_RELOAD,   3'd1, 32'h0, ST_UNSET);
      send_req(CMD_RD_PENDING,  3'd1, 32'h0, ST_UNSET);
      send_req(CMD_WR_STATUS,   3'd5, 32'h0, ST_MISSED);
      send_req(CMD_CHECK,       3'd0, 32'h0, ST_UNSET);
      send_req(CMD_CHECK,       3'd7, 32'h0, ST_UNSET);
      send_req(CMD_UNUSED_LO,   3'd6, 32'hFFFF_FFFF, ST_INVALID);
      send_req(CMD_UNUSED_HI,   3'd1, 32'h0, ST_UNSET);
      send_req(CMD_TICK,        3'd0, 32'h0, ST_UNSET);
      send_req(CMD_RD_RELOAD,   3'd3, 32'h0, ST_UNSET);
      send_req(CMD_RD_DEADLINE, 3'd6, 32'h0, ST_UNSET);

      // Random: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 77; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin req_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Fill the core against a long receiver hold-off
            if (phase == 0 && n == 100) hold_requests++;
            pick = $urandom_range(99);
            if      (pick < 28) cmd = CMD_TICK;
            else if (pick < 36) cmd = CMD_WR_DEADLINE;
            else if (pick < 46) cmd = CMD_WR_STATUS;
            else if (pick < 52) cmd = CMD_WR_RELOAD;
            else if (pick < 60) cmd = CMD_WR_PENDING;
            else if (pick < 68) cmd = CMD_RD_DEADLINE;
            else if (pick < 75) cmd = CMD_RD_RELOAD;
            else if (pick < 81) cmd = CMD_RD_PENDING;
            else if (pick < 93) cmd = CMD_CHECK;
            else cmd = DLRT_CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            if ($urandom_range(9) == 0) st = ST_INVALID;
            else                        st = status_type'($urandom_range(2));
            send_req(cmd, DLRT_INDEX_W'($urandom_range(7)), pick_value(), st);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow for the pipeline
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> deadline_and_reload_timer_bank_core.f
hw/rtl/dlrt_pkg.sv
hw/rtl/dlrt_deadline_bank.sv
hw/rtl/dlrt_reload_bank.sv
hw/rtl/deadline_and_reload_timer_bank_core.sv
dv/dlrt_rsp_checker.sv
dv/deadline_and_reload_timer_bank_core_tb.sv
